// ----- sv/lrs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared constants and types of the longest repeated substring scanner.
// ----------------------------------------------------------------------------
package lrs_pkg;

    localparam int MAX_TEXT_DEF  = 1024;
    localparam int NUM_CELLS_DEF = 32;
    localparam int BYTE_W        = 8;
    localparam int OUT_W         = 11;

    // Sideband that travels with each compare slot into every cell.
    typedef struct packed {
        logic v;
        logic first;
    } t_ctl;

    // One tap of the shifting text line: a byte and whether it lies inside the text.
    typedef struct packed {
        logic              ok;
        logic [BYTE_W-1:0] b;
    } t_tap;

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

endpackage

// ----- sv/longest_repeat_substring_scan_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_repeat_substring_scan_top
// Buffers a text one byte per word and, after the last byte, finds the
// longest substring that occurs twice, using a row of diagonal compare cells.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   input    | start, busy          | i_text_byte, i_is_last
//   result   | o_valid (one cycle)  | o_match_start, o_match_end, o_overflowed
//
// A byte that is not the last is accepted whenever start is high; busy stays low while loading.
// With n bytes held and K cells, the search walks ceil((n-1)/K) batches of K
// diagonals, each batch stepping its position down through the two read ports
// of the text RAM, then drains the cell row, then shows the result.
// Busy is high from the last byte to the result.
// Reset returns to loading with an empty buffer. The receiver cannot stall.
// ----------------------------------------------------------------------------
module longest_repeat_substring_scan_top #(
    parameter int MAX_TEXT  = lrs_pkg::MAX_TEXT_DEF,
    parameter int NUM_CELLS = lrs_pkg::NUM_CELLS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [lrs_pkg::BYTE_W-1:0] i_text_byte,
    input  logic                       i_is_last,
    output logic                       o_valid,
    output logic [lrs_pkg::OUT_W-1:0]  o_match_start,
    output logic [lrs_pkg::OUT_W-1:0]  o_match_end,
    output logic                       o_overflowed
);
    import lrs_pkg::*;

    localparam int AW  = $clog2(MAX_TEXT);
    localparam int CW  = $clog2(MAX_TEXT + 1);
    localparam int SW  = $clog2(MAX_TEXT + NUM_CELLS + 1);
    localparam int DCW = $clog2(NUM_CELLS + 1);

    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic           r_ovf, n_ovf;
    logic [AW-1:0]  r_d0, n_d0;
    logic [AW-1:0]  r_pa, n_pa;
    logic           r_first, n_first;
    logic [DCW-1:0] r_drain, n_drain;

    logic           r_v1;
    logic           r_first1;
    logic [AW-1:0]  r_p1;

    logic [AW-1:0]  r_best_len;
    logic [AW-1:0]  r_best_start;

    logic              full;
    logic              we;
    logic              clr_best;
    logic [CW-1:0]     cnt_new;
    logic [SW-1:0]     d_next;
    logic [BYTE_W-1:0] rd_a;
    logic [BYTE_W-1:0] rd_b;
    logic              take_best;
    t_ctl              ctl;

    t_tap          tap        [NUM_CELLS+1];
    logic [AW-1:0] cand_len   [NUM_CELLS+1];
    logic [AW-1:0] cand_start [NUM_CELLS+1];

    // ---------------- control ----------------
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_d0     = r_d0;
        n_pa     = r_pa;
        n_first  = r_first;
        n_drain  = r_drain;
        we       = 1'b0;
        clr_best = 1'b0;
        full     = (r_count == CW'(MAX_TEXT));
        cnt_new  = full ? r_count : r_count + CW'(1);
        d_next   = SW'(r_d0) + SW'(NUM_CELLS);

        unique case (r_state)
            S_LOAD: begin
                if (start) begin
                    we      = ~full;
                    n_ovf   = r_ovf | full;
                    n_count = cnt_new;
                    if (i_is_last) begin
                        clr_best = 1'b1;
                        if (cnt_new >= CW'(2)) begin
                            n_state = S_SCAN;
                            n_d0    = AW'(1);
                            n_pa    = AW'(cnt_new - CW'(2));
                            n_first = 1'b1;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (r_pa == '0) begin
                    if (d_next < SW'(r_count)) begin
                        // Next batch starts at the last position whose partner fits.
                        n_d0    = AW'(d_next);
                        n_pa    = AW'(SW'(r_count) - SW'(1) - d_next);
                        n_first = 1'b1;
                    end else begin
                        n_state = S_DRAIN;
                        n_drain = '0;
                        n_first = 1'b0;
                    end
                end else begin
                    n_pa    = r_pa - AW'(1);
                    n_first = 1'b0;
                end
            end
            S_DRAIN: begin
                if (r_drain == DCW'(NUM_CELLS)) begin
                    n_state = S_DONE;
                end else begin
                    n_drain = r_drain + DCW'(1);
                end
            end
            S_DONE: begin
                n_state = S_LOAD;
                n_count = '0;
                n_ovf   = 1'b0;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_first <= 1'b0;
            r_drain <= '0;
            r_v1    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_first <= n_first;
            r_drain <= n_drain;
            r_v1    <= (r_state == S_SCAN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_d0     <= n_d0;
        r_pa     <= n_pa;
        r_first1 <= r_first;
        r_p1     <= r_pa;
    end

    // ---------------- text buffer ----------------
    lrs_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_TEXT)
    ) u_text (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (r_count[AW-1:0]),
        .i_wdata   (i_text_byte),
        .i_raddr_a (r_pa),
        .i_raddr_b (r_pa + r_d0),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // ---------------- cell row ----------------
    // Cell k compares text[p] with text[p + d0 + k]; the partner byte enters
    // cell 0 and moves one cell per cycle while p counts down.
    assign ctl           = '{v: r_v1, first: r_first1};
    assign tap[0]        = '{ok: r_v1, b: rd_b};
    assign cand_len[0]   = '0;
    assign cand_start[0] = '0;

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        lrs_cell #(
            .AW (AW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_a          (rd_a),
            .i_p          (r_p1),
            .i_tap        (tap[k]),
            .o_tap        (tap[k+1]),
            .i_cand_len   (cand_len[k]),
            .i_cand_start (cand_start[k]),
            .o_cand_len   (cand_len[k+1]),
            .o_cand_start (cand_start[k+1])
        );
    end

    // ---------------- best match ----------------
    always_comb begin
        take_best = (cand_len[NUM_CELLS] > r_best_len) ||
                    (cand_len[NUM_CELLS] == r_best_len && cand_len[NUM_CELLS] != '0 &&
                     cand_start[NUM_CELLS] < r_best_start);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr_best) begin
            r_best_len   <= '0;
            r_best_start <= '0;
        end else if (take_best) begin
            r_best_len   <= cand_len[NUM_CELLS];
            r_best_start <= cand_start[NUM_CELLS];
        end
    end

    assign busy          = (r_state != S_LOAD);
    assign o_valid       = (r_state == S_DONE);
    assign o_match_start = OUT_W'(r_best_start);
    assign o_match_end   = OUT_W'(CW'(r_best_start) + CW'(r_best_len));
    assign o_overflowed  = r_ovf;

endmodule

// ----- sv/lrs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module lrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

// ----- sv/lrs_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_cell
// One diagonal of the scan: compares the broadcast byte with its tap of the
// text line, keeps the run length and folds its hit into the candidate chain.
// ----------------------------------------------------------------------------
module lrs_cell #(
    parameter int AW = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lrs_pkg::t_ctl              i_ctl,
    input  logic [lrs_pkg::BYTE_W-1:0] i_a,
    input  logic [AW-1:0]              i_p,
    input  lrs_pkg::t_tap              i_tap,
    output lrs_pkg::t_tap              o_tap,
    input  logic [AW-1:0]              i_cand_len,
    input  logic [AW-1:0]              i_cand_start,
    output logic [AW-1:0]              o_cand_len,
    output logic [AW-1:0]              o_cand_start
);
    import lrs_pkg::*;

    t_tap          r_tap;
    logic [AW-1:0] r_run;
    logic [AW-1:0] r_cand_len;
    logic [AW-1:0] r_cand_start;
    logic [AW-1:0] prev_run;
    logic [AW-1:0] run_next;
    logic          hit;
    logic          take_own;

    always_comb begin
        prev_run = i_ctl.first ? '0 : r_run;
        hit      = i_ctl.v & i_tap.ok & (i_tap.b == i_a);
        run_next = hit ? prev_run + AW'(1) : '0;
        take_own = hit && ((run_next > i_cand_len) ||
                           (run_next == i_cand_len && i_p < i_cand_start));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap      <= '0;
            r_run      <= '0;
            r_cand_len <= '0;
        end else begin
            r_tap      <= i_tap;
            r_cand_len <= take_own ? run_next : i_cand_len;
            if (i_ctl.v) begin
                r_run <= run_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand_start <= take_own ? i_p : i_cand_start;
    end

    // On the first slot of a new diagonal batch, whatever the line still holds
    // belongs to the old batch and lies past the end of the text.
    assign o_tap.ok     = r_tap.ok & ~i_ctl.first;
    assign o_tap.b      = r_tap.b;
    assign o_cand_len   = r_cand_len;
    assign o_cand_start = r_cand_start;

endmodule

// ----- sv/lrs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_checker
// Port-level checks of the scanner, bound to its top level.
// ----------------------------------------------------------------------------
module lrs_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       i_is_last,
    input logic                       o_valid,
    input logic [lrs_pkg::OUT_W-1:0]  o_match_start,
    input logic [lrs_pkg::OUT_W-1:0]  o_match_end
);

    // A word that does not end the text never starts a search.
    a_load_stays_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_is_last) |=> !busy)
        else $error("busy rose after a word that was not the last");

    // The result is shown while the block is still busy, and it is done afterward.
    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result shown while idle");

    a_result_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!busy && !o_valid))
        else $error("block did not return to loading after its result");

    // An empty match is always reported at position zero.
    a_empty_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_match_end == o_match_start) |-> o_match_start == '0)
        else $error("empty match reported away from position zero");

    // The last word of a text always raises busy for the search and its result.
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_is_last) |=> busy)
        else $error("last word did not start a search");

endmodule

bind longest_repeat_substring_scan_top lrs_checker u_lrs_checker (.*);
